### rtl/wfd_pkg.sv
`timescale 1ns / 1ps

package wfd_pkg;

   localparam int LimbW    = 64;
   localparam int Limbs    = 4;
   localparam int IndexW   = 2;
   localparam int TargetW  = LimbW * Limbs;
   localparam int DataW    = 72;
   localparam int StepW    = 8;
   localparam logic [IndexW-1:0] LastIndex = IndexW'(Limbs - 1);

   typedef logic [LimbW-1:0]   limb_type;
   typedef logic [TargetW-1:0] target_type;

   // one complete target handed from the front to the queue
   typedef struct packed {
      logic       valid;
      target_type target;
   } push_type;

   // queue status seen by the producer and the consumer
   typedef struct packed {
      logic       full;
      logic       empty;
      target_type head;
   } queue_stat_type;

endpackage

### rtl/wfd_front.sv
`timescale 1ns / 1ps

module wfd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [wfd_pkg::DataW-1:0] req_tdata,
   input  logic                  queue_full,
   output wfd_pkg::push_type     push
);

   wfd_pkg::limb_type limb_ff [wfd_pkg::Limbs-1];
   logic [wfd_pkg::IndexW-1:0] index;
   wfd_pkg::limb_type          value;
   logic                       accept;

   assign index      = req_tdata[wfd_pkg::IndexW-1:0];
   assign value      = req_tdata[wfd_pkg::IndexW +: wfd_pkg::LimbW];
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // lower limbs are kept; the top limb goes straight into the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wfd_pkg::Limbs - 1; i++) begin
            limb_ff[i] <= '0;
         end
      end else if (accept && index != wfd_pkg::LastIndex) begin
         limb_ff[index] <= value;
      end
   end

   always_comb begin
      push.valid  = accept && (index == wfd_pkg::LastIndex);
      push.target = {value, limb_ff[2], limb_ff[1], limb_ff[0]};
   end

endmodule

### rtl/wfd_queue.sv
`timescale 1ns / 1ps

module wfd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  wfd_pkg::push_type          push,
   input  logic                       pop,
   output wfd_pkg::queue_stat_type    stat
);

   wfd_pkg::target_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign do_push = push.valid && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      stat.full  = (count_ff == 2'd2);
      stat.empty = (count_ff == 2'd0);
      stat.head  = entry_ff[rd_ptr_ff];
   end

endmodule

### rtl/wfd_back.sv
`timescale 1ns / 1ps

module wfd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  wfd_pkg::queue_stat_type     stat,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [wfd_pkg::DataW-1:0]   rsp_tdata,
   output logic                        rsp_tlast
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StInc  = 2'd2;
   localparam logic [1:0] StEmit = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [wfd_pkg::StepW-1:0]  step_ff, step_in;
   logic [wfd_pkg::IndexW-1:0] emit_ff, emit_in;
   wfd_pkg::target_type rem_ff, rem_in;
   wfd_pkg::target_type dq_ff, dq_in;
   wfd_pkg::target_type div_ff, div_in;
   wfd_pkg::target_type work_ff, work_in;
   logic divz_ff, divz_in;

   logic out_valid_ff, out_valid_in;
   logic [wfd_pkg::IndexW-1:0] out_index_ff, out_index_in;
   wfd_pkg::limb_type          out_value_ff, out_value_in;
   logic out_last_ff, out_last_in;

   logic [wfd_pkg::TargetW:0]   shifted;
   logic [wfd_pkg::TargetW+1:0] diff;
   logic                        ge;
   logic                        out_free;

   // one restoring step: bring in the next dividend bit and try the subtract
   assign shifted  = {rem_ff, dq_ff[wfd_pkg::TargetW-1]};
   assign diff     = {1'b0, shifted} - {2'b00, div_ff};
   assign ge       = !diff[wfd_pkg::TargetW+1];
   assign out_free = !out_valid_ff || rsp_tready;
   assign pop      = (state_ff == StIdle) && !stat.empty;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      div_in       = div_ff;
      divz_in      = divz_ff;
      work_in      = work_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         StIdle: begin
            if (!stat.empty) begin
               dq_in    = ~stat.head;
               div_in   = stat.head + wfd_pkg::TargetW'(1);
               divz_in  = &stat.head;
               rem_in   = '0;
               step_in  = '0;
               state_in = StDiv;
            end
         end
         StDiv: begin
            rem_in  = ge ? diff[wfd_pkg::TargetW-1:0] : shifted[wfd_pkg::TargetW-1:0];
            dq_in   = {dq_ff[wfd_pkg::TargetW-2:0], ge};
            step_in = step_ff + 1'b1;
            if (&step_ff) begin
               state_in = StInc;
            end
         end
         StInc: begin
            // zero divisor gives a zero quotient
            work_in  = (divz_ff ? '0 : dq_ff) + wfd_pkg::TargetW'(1);
            emit_in  = '0;
            state_in = StEmit;
         end
         StEmit: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = emit_ff;
               out_value_in = work_ff[emit_ff * wfd_pkg::LimbW +: wfd_pkg::LimbW];
               out_last_in  = (emit_ff == wfd_pkg::LastIndex);
               emit_in      = emit_ff + 1'b1;
               if (emit_ff == wfd_pkg::LastIndex) begin
                  state_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         step_ff      <= '0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      div_ff       <= div_in;
      divz_ff      <= divz_in;
      work_ff      <= work_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(wfd_pkg::DataW - wfd_pkg::IndexW - wfd_pkg::LimbW){1'b0}},
                        out_value_ff, out_index_ff};

endmodule

### rtl/work_from_target_divider.sv
`timescale 1ns / 1ps
// channel  direction  transaction
// req_     in         target limb: index and 64-bit value
// rsp_     out        work limb: index, 64-bit value, tlast on limb 3
//
// limbs 0..2 are stored as they are accepted; limb 3 queues the target
// the divider takes a target through a load, 256 steps of one
// quotient bit each and an increment, then emits the four work limbs
// rsp stalls hold the emit
// a two-entry queue lets limbs keep arriving while the divider runs
// reset is synchronous and clears stored limbs and all control state

module work_from_target_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [wfd_pkg::DataW-1:0]  req_tdata,   // limb_index, limb_value
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [wfd_pkg::DataW-1:0]  rsp_tdata,   // work_limb_index, work_limb_value
   output logic                       rsp_tlast
);

   wfd_pkg::push_type       push;
   wfd_pkg::queue_stat_type stat;
   logic                    pop;

   wfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (stat.full),
      .push       (push)
   );

   wfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .stat  (stat)
   );

   wfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### bench/work_from_target_divider_tb.sv
`timescale 1ns / 1ps

module work_from_target_divider_tb;
   import wfd_pkg::*;

   localparam int HalfPeriod  = 10;
   localparam int ResetCycles = 9;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 600;
   localparam int RandomItems = 110;

   typedef struct packed {
      logic [IndexW-1:0] index;
      limb_type          value;
   } target_limb_type;

   typedef struct packed {
      logic [IndexW-1:0] index;
      limb_type          value;
      logic              last;
   } work_limb_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [DataW-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [DataW-1:0] rsp_tdata;
   logic             rsp_tlast;

   target_limb_type pending_limbs[$];
   work_limb_type   expected_work[$];
   limb_type        target_limbs[Limbs];

   int error_count  = 0;
   int limbs_sent   = 0;
   int divisions    = 0;
   int work_checked = 0;
   int cycle_count  = 0;

   work_from_target_divider u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HalfPeriod clock = ~clock;

   function automatic logic [DataW-1:0] pack_limb(target_limb_type limb);
      logic [DataW-1:0] word;
      word                    = '0;
      word[IndexW-1:0]        = limb.index;
      word[IndexW +: LimbW]   = limb.value;
      return word;
   endfunction

   // random gaps, none while the count sits inside the quiet window
   function automatic bit take_break(int count, int quiet_lo, int quiet_hi);
      if (count >= quiet_lo && count < quiet_hi) return 1'b0;
      return $urandom_range(99) < 6;
   endfunction

   // zero and all-ones limbs often, so that wraps and tiny targets come up
   function automatic limb_type random_limb(bit high_limb);
      int pick;
      pick = $urandom_range(99);
      if (pick < (high_limb ? 35 : 15)) return '0;
      if (pick < (high_limb ? 50 : 30)) return '1;
      if (pick < (high_limb ? 65 : 40)) return limb_type'($urandom_range(65535));
      return {$urandom, $urandom};
   endfunction

   task automatic add_limb(int index, limb_type value);
      pending_limbs.push_back(target_limb_type'{index: IndexW'(index), value: value});
   endtask

   task automatic report_mismatch(string what, limb_type got, limb_type want);
      $display("ERROR cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // work = ~t / (t + 1) + 1 mod 2^256, zero divisor gives zero quotient
   task automatic predict_work();
      target_type target;
      target_type divisor;
      target_type work;
      for (int i = 0; i < Limbs; i++) target[i*LimbW +: LimbW] = target_limbs[i];
      divisor = target + 1;
      work    = (divisor == '0) ? '0 : ~target / divisor;
      work    = work + 1;
      for (int k = 0; k < Limbs; k++) begin
         expected_work.push_back(work_limb_type'{index: IndexW'(k),
                                                 value: work[k*LimbW +: LimbW],
                                                 last:  (k == Limbs - 1)});
      end
   endtask

   task automatic accept_limb(target_limb_type limb);
      target_limbs[limb.index] = limb.value;
      limbs_sent++;
      if (limb.index == LastIndex) begin
         divisions++;
         predict_work();
      end
   endtask

   task automatic check_work_limb();
      work_limb_type got;
      work_limb_type want;
      got.index = rsp_tdata[IndexW-1:0];
      got.value = rsp_tdata[IndexW +: LimbW];
      got.last  = rsp_tlast;
      work_checked++;
      if (expected_work.size() == 0) begin
         report_mismatch("unexpected work limb", got.value, '0);
      end else begin
         want = expected_work.pop_front();
         if (got.index != want.index)
            report_mismatch("work limb index", limb_type'(got.index), limb_type'(want.index));
         if (got.value != want.value)
            report_mismatch($sformatf("work limb %0d value", want.index), got.value, want.value);
         if (got.last != want.last)
            report_mismatch($sformatf("work limb %0d tlast", want.index),
                            limb_type'(got.last), limb_type'(want.last));
      end
   endtask

   // driver: one transaction in flight, held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         for (int i = 0; i < Limbs; i++) target_limbs[i] = '0;
      end else begin
         if (req_tvalid && req_tready) accept_limb(pending_limbs.pop_front());
         if (!req_tvalid || req_tready) begin
            if (pending_limbs.size() > 0 && !take_break(limbs_sent, 40, 75)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pack_limb(pending_limbs[0]);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_work_limb();
         rsp_tready <= !take_break(work_checked, 50, 90);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d work limbs outstanding",
                  cycle_count, expected_work.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int order[3];
      int kind;
      int count;
      int pick;
      int swap;

      // target zero straight after reset, work wraps to zero
      add_limb(LastIndex, '0);
      // only the top limb written
      add_limb(LastIndex, {$urandom, $urandom});
      // target one
      add_limb(0, 64'd1);
      add_limb(1, '0);
      add_limb(2, '0);
      add_limb(LastIndex, '0);
      // all ones, divisor wraps to zero
      for (int i = 0; i < Limbs; i++) add_limb(i, '1);
      // 2^255 - 1
      add_limb(LastIndex, 64'h7fff_ffff_ffff_ffff);
      // single bit in the low limb, limbs out of order
      add_limb(2, '0);
      add_limb(1, '0);
      add_limb(0, 64'h8000_0000_0000_0000);
      add_limb(LastIndex, '0);
      add_limb(LastIndex, 64'h8000_0000_0000_0000);
      add_limb(1, '1);
      add_limb(LastIndex, '0);
      add_limb(2, 64'h0000_0000_0000_0001);
      add_limb(LastIndex, '0);

      while (pending_limbs.size() < RandomItems) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            order = '{0, 1, 2};
            for (int i = 2; i > 0; i--) begin
               pick        = $urandom_range(i);
               swap        = order[i];
               order[i]    = order[pick];
               order[pick] = swap;
            end
            count = (kind < 65) ? 3 : $urandom_range(2);
            for (int j = 0; j < count; j++) add_limb(order[j], random_limb(1'b0));
            add_limb(LastIndex, random_limb(1'b1));
         end else begin
            count = $urandom_range(3, 1);
            for (int j = 0; j < count; j++) begin
               pick = $urandom_range(3);
               add_limb(pick, (pick == LastIndex) ? random_limb(1'b1) : {$urandom, $urandom});
            end
         end
      end

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      while (pending_limbs.size() > 0 || req_tvalid) @(negedge clock);
      while (expected_work.size() > 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("sent %0d target limbs covering %0d work computations", limbs_sent, divisions);
      $display("checked %0d work limbs, %0d mismatches", work_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
